FILE: design/assert_macros.svh
// assertion shorthands, sampled on clk_i and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property
`define PSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// same-cycle implication
`define PSD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: design/psd_pkg.sv
package psd_pkg;

  localparam int unsigned PageMin  = 512;
  localparam int unsigned PageMax  = 65536;
  localparam int unsigned SlotMax  = 65535;
  localparam int unsigned PctScale = 100;
  localparam int unsigned PageRst  = 4096;

  typedef enum logic [2:0] {
    MODE_READ      = 3'd0,
    MODE_WRITE     = 3'd1,
    MODE_INSERT    = 3'd2,
    MODE_REMOVE    = 3'd3,
    MODE_SET_START = 3'd4,
    MODE_CLEAR     = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    CFG_PAGE_SIZE = 2'd0,
    CFG_INTERIOR  = 2'd1,
    CFG_OVER_PCT  = 2'd2,
    CFG_UNDER_PCT = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [10:0] slot_index;
    logic [16:0] offset_value;
  } psd_in_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] pointer_value;
    logic [11:0] cell_count;
    logic [16:0] content_offset;
    logic [16:0] used_bytes;
    logic [16:0] free_bytes;
    logic        overfull;
    logic        underfull;
  } psd_out_t;

endpackage

FILE: design/page_slot_directory.sv
// channel   | direction | handshake                   | payload
// ----------+-----------+-----------------------------+------------
// in        | input     | in_valid_i / in_stall_o     | psd_in_t
// out       | output    | out_valid_o / out_stall_i   | psd_out_t
// cfg       | input     | cfg_we_i, cfg_idx_i         | cfg_data_i
//
// one item at a time; insert and remove shift the slots that lie between slot_index and
// the last cell when slots move, and skip the shift when appending or removing the last
// slot; one move per cycle
// clear page sweeps the slot ram
// after reset a zeroing pass over the slot ram runs with in_stall_o high
// the result sits in an output register; the next item is taken while it waits
`include "assert_macros.svh"

module page_slot_directory
  import psd_pkg::*;
#(
  parameter int unsigned MAX_CELLS             = 2048,
  parameter int unsigned LEAF_HEADER_BYTES     = 8,
  parameter int unsigned INTERIOR_HEADER_BYTES = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  psd_in_t     in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output psd_out_t    out_item_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [16:0] cfg_data_i
);

  // address, count and compare widths
  localparam int unsigned AW = $clog2(MAX_CELLS);
  localparam int unsigned CW = $clog2(MAX_CELLS + 1);
  localparam int unsigned XW = (CW > 12) ? CW : 12;
  localparam int unsigned FW = (XW + 2 > 18) ? XW + 2 : 18;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_RDWAIT, S_SHIFT, S_FINAL, S_FILL1, S_FILL2, S_FILL3
  } state_e;

  state_e state_q;

  // configuration
  logic [16:0] page_size_q;
  logic        interior_q;
  logic [6:0]  over_pct_q;
  logic [6:0]  under_pct_q;

  // page state
  logic [CW-1:0] cnt_q;
  logic [16:0]   cstart_q;

  // latched item and result
  logic [2:0]  mode_q;
  logic [10:0] idx_q;
  logic [16:0] val_q;
  logic        ok_q;
  logic [15:0] ptr_q;
  logic        res_pend_q;

  // sweep and shift pointers
  logic [AW-1:0] clr_q;
  logic [AW-1:0] rd_q;
  logic [AW-1:0] end_q;
  logic          rd_live_q;
  logic          wb_valid_q;
  logic [AW-1:0] wb_q;

  // fill pipeline
  logic [16:0] used_q;
  logic [23:0] mul_used_q;
  logic [24:0] thr_over_q;
  logic [23:0] thr_under_q;

  logic     out_valid_q;
  psd_out_t out_item_q;

  // ram ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;

  // effective geometry
  logic [16:0]   eff_page;
  logic [6:0]    hdr;
  logic [XW-1:0] idx_x;
  logic [XW-1:0] cnt_x;
  logic [XW-1:0] max_x;
  logic          fits_idx;
  logic          fits_cnt;
  logic          val_slot_ok;
  logic          val_start_ok;
  logic          rw_ok;
  logic          ins_ok;
  logic          rem_ok;
  logic [AW-1:0] idx_a;
  logic [AW-1:0] cnt_m1_a;
  logic          is_insert;

  // fill stage one
  logic [16:0] cs_clamp;
  logic [FW:0] used_raw;
  logic [16:0] used_sat;

  always_comb begin
    if (page_size_q < 17'(PageMin)) begin
      eff_page = 17'(PageMin);
    end else if (page_size_q > 17'(PageMax)) begin
      eff_page = 17'(PageMax);
    end else begin
      eff_page = page_size_q;
    end
  end

  assign hdr          = interior_q ? 7'(INTERIOR_HEADER_BYTES) : 7'(LEAF_HEADER_BYTES);
  assign idx_x        = XW'(idx_q);
  assign cnt_x        = XW'(cnt_q);
  assign max_x        = XW'(MAX_CELLS);
  // slot k fits when header + 2k + 2 stays within the page
  assign fits_idx     = (FW'(hdr) + (FW'(idx_x) << 1) + FW'(2)) <= FW'(eff_page);
  assign fits_cnt     = (FW'(hdr) + (FW'(cnt_x) << 1) + FW'(2)) <= FW'(eff_page);
  assign val_slot_ok  = val_q <= 17'(SlotMax);
  assign val_start_ok = val_q <= 17'(PageMax);
  assign rw_ok        = (idx_x < max_x) && fits_idx;
  assign ins_ok       = (idx_x <= cnt_x) && (cnt_x < max_x) && fits_cnt && val_slot_ok;
  assign rem_ok       = idx_x < cnt_x;
  assign idx_a        = AW'(idx_q);
  assign cnt_m1_a     = AW'(cnt_q - CW'(1));
  assign is_insert    = mode_q == MODE_INSERT;

  // used = header + 2 per cell + content area, content start clamped to page
  assign cs_clamp = (cstart_q > eff_page) ? eff_page : cstart_q;
  assign used_raw = (FW + 1)'(hdr) + ((FW + 1)'(cnt_q) << 1) + (FW + 1)'(eff_page - cs_clamp);
  assign used_sat = (used_raw > (FW + 1)'(eff_page)) ? eff_page : used_raw[16:0];

  // ram access per state
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
      end
      S_DECODE: begin
        if (mode_q == MODE_READ && rw_ok) begin
          ram_re    = 1'b1;
          ram_raddr = idx_a;
        end
        if (mode_q == MODE_WRITE && rw_ok && val_slot_ok) begin
          ram_we    = 1'b1;
          ram_waddr = idx_a;
          ram_wdata = val_q[15:0];
        end
      end
      S_SHIFT: begin
        // read one slot ahead while the previous one lands at its neighbor
        if (rd_live_q) begin
          ram_re    = 1'b1;
          ram_raddr = rd_q;
        end
        if (wb_valid_q) begin
          ram_we    = 1'b1;
          ram_waddr = wb_q;
          ram_wdata = ram_rdata;
        end
      end
      S_FINAL: begin
        if (is_insert) begin
          ram_we    = 1'b1;
          ram_waddr = idx_a;
          ram_wdata = val_q[15:0];
        end
      end
      default: begin
      end
    endcase
  end

  psd_ram #(
    .WIDTH (16),
    .DEPTH (MAX_CELLS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      page_size_q <= 17'(PageRst);
      interior_q  <= 1'b0;
      over_pct_q  <= 7'd100;
      under_pct_q <= 7'd0;
      cnt_q       <= '0;
      cstart_q    <= 17'(PageRst);
      res_pend_q  <= 1'b0;
      clr_q       <= '0;
      rd_live_q   <= 1'b0;
      wb_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PAGE_SIZE: page_size_q <= cfg_data_i;
          CFG_INTERIOR:  interior_q  <= cfg_data_i[0];
          CFG_OVER_PCT:  over_pct_q  <= cfg_data_i[6:0];
          CFG_UNDER_PCT: under_pct_q <= cfg_data_i[6:0];
          default: begin
          end
        endcase
      end

      // a result leaving while a new one is loaded is handled in S_FILL3
      if (out_valid_q && !out_stall_i && state_q != S_FILL3) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_CLEAR: begin
          if (clr_q == AW'(MAX_CELLS - 1)) begin
            clr_q   <= '0;
            state_q <= res_pend_q ? S_FILL1 : S_IDLE;
          end else begin
            clr_q <= clr_q + AW'(1);
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            mode_q  <= in_item_i.mode;
            idx_q   <= in_item_i.slot_index;
            val_q   <= in_item_i.offset_value;
            ok_q    <= 1'b0;
            ptr_q   <= '0;
            state_q <= S_DECODE;
          end
        end
        S_DECODE: begin
          case (mode_q)
            MODE_READ: begin
              if (rw_ok) begin
                ok_q    <= 1'b1;
                state_q <= S_RDWAIT;
              end else begin
                state_q <= S_FILL1;
              end
            end
            MODE_WRITE: begin
              ok_q    <= rw_ok && val_slot_ok;
              state_q <= S_FILL1;
            end
            MODE_INSERT: begin
              if (ins_ok) begin
                ok_q  <= 1'b1;
                cnt_q <= cnt_q + CW'(1);
                if (idx_x < cnt_x) begin
                  rd_q      <= cnt_m1_a;
                  end_q     <= idx_a;
                  rd_live_q <= 1'b1;
                  state_q   <= S_SHIFT;
                end else begin
                  state_q <= S_FINAL;
                end
              end else begin
                state_q <= S_FILL1;
              end
            end
            MODE_REMOVE: begin
              if (rem_ok) begin
                ok_q  <= 1'b1;
                cnt_q <= cnt_q - CW'(1);
                if (idx_x + XW'(1) < cnt_x) begin
                  rd_q      <= idx_a + AW'(1);
                  end_q     <= cnt_m1_a;
                  rd_live_q <= 1'b1;
                  state_q   <= S_SHIFT;
                end else begin
                  state_q <= S_FILL1;
                end
              end else begin
                state_q <= S_FILL1;
              end
            end
            MODE_SET_START: begin
              if (val_start_ok) begin
                ok_q     <= 1'b1;
                cstart_q <= val_q;
              end
              state_q <= S_FILL1;
            end
            MODE_CLEAR: begin
              ok_q       <= 1'b1;
              cnt_q      <= '0;
              cstart_q   <= eff_page;
              res_pend_q <= 1'b1;
              clr_q      <= '0;
              state_q    <= S_CLEAR;
            end
            default: begin
              state_q <= S_FILL1;
            end
          endcase
        end
        S_RDWAIT: begin
          ptr_q   <= ram_rdata;
          state_q <= S_FILL1;
        end
        S_SHIFT: begin
          wb_valid_q <= rd_live_q;
          if (rd_live_q) begin
            wb_q <= is_insert ? rd_q + AW'(1) : rd_q - AW'(1);
            if (rd_q == end_q) begin
              rd_live_q <= 1'b0;
            end else begin
              rd_q <= is_insert ? rd_q - AW'(1) : rd_q + AW'(1);
            end
          end
          if (!rd_live_q && !wb_valid_q) begin
            state_q <= is_insert ? S_FINAL : S_FILL1;
          end
        end
        S_FINAL: begin
          state_q <= S_FILL1;
        end
        S_FILL1: begin
          res_pend_q <= 1'b0;
          used_q     <= used_sat;
          state_q    <= S_FILL2;
        end
        S_FILL2: begin
          // pct > X  <=>  used*100 >= (X+1)*page ; pct < U  <=>  used*100 < U*page
          mul_used_q  <= 24'(used_q) * 24'(PctScale);
          thr_over_q  <= 25'(8'(over_pct_q) + 8'd1) * 25'(eff_page);
          thr_under_q <= 24'(under_pct_q) * 24'(eff_page);
          state_q     <= S_FILL3;
        end
        S_FILL3: begin
          if (!out_valid_q || !out_stall_i) begin
            out_item_q.ok             <= ok_q;
            out_item_q.pointer_value  <= ptr_q;
            out_item_q.cell_count     <= 12'(cnt_q);
            out_item_q.content_offset <= cstart_q;
            out_item_q.used_bytes     <= used_q;
            out_item_q.free_bytes     <= eff_page - used_q;
            out_item_q.overfull       <= 25'(mul_used_q) >= thr_over_q;
            out_item_q.underfull      <= mul_used_q < thr_under_q;
            out_valid_q               <= 1'b1;
            state_q                   <= S_IDLE;
          end else begin
            out_valid_q <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `PSD_ASSERT(a_cnt_cap, cnt_q <= CW'(MAX_CELLS), "cell count beyond capacity")
  `PSD_ASSERT_IMP(a_no_collide, ram_we && ram_re, ram_waddr != ram_raddr, "shift collision")
  `PSD_ASSERT_IMP(a_out_src, $rose(out_valid_q), $past(state_q) == S_FILL3, "stray result")
  `PSD_ASSERT_IMP(a_clr_stall, state_q == S_CLEAR, in_stall_o, "item taken while sweeping")

endmodule

FILE: design/psd_ram.sv
module psd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
